[hw/rtl/arp_cache_and_receive_core_macros.svh]
// Assertion macros for the ARP cache checker.
// Expects clk and rst_n in the scope of each use.
`ifndef ARP_CACHE_AND_RECEIVE_CORE_MACROS_SVH
`define ARP_CACHE_AND_RECEIVE_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define ARPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define ARPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/arpc_pkg.sv]
// Shared constants, codes and widths for the ARP cache and receive core.
// No dependencies; the interfaces, core and checker use it by scoped names.
package arpc_pkg;

  // Table geometry
  localparam int TABLE_ENTRIES = 32;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // Field widths
  localparam int MAC_W   = 48;
  localparam int IP_W    = 32;
  localparam int WORD_W  = MAC_W + IP_W;
  localparam int FUNC_W  = 3;
  localparam int STAT_W  = 3;
  localparam int PLEN_W  = 11;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 64;

  // Operation codes
  localparam logic [FUNC_W-1:0] FN_ADD      = 3'd0;
  localparam logic [FUNC_W-1:0] FN_FIND_IP  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_FIND_MAC = 3'd2;
  localparam logic [FUNC_W-1:0] FN_DEL_MAC  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_DEL_IP   = 3'd4;
  localparam logic [FUNC_W-1:0] FN_RECEIVE  = 3'd5;
  localparam logic [FUNC_W-1:0] FN_RESOLVE  = 3'd6;

  // ARP header constants
  localparam logic [15:0] HW_ETHERNET = 16'h0001;
  localparam logic [15:0] PROTO_IPV4  = 16'h0800;
  localparam logic [15:0] OP_REQUEST  = 16'h0001;
  localparam logic [15:0] OP_REPLY    = 16'h0002;

  // Register indexes, selected by paddr bit 3
  localparam logic REG_LOCAL_IP  = 1'b0;
  localparam logic REG_LOCAL_MAC = 1'b1;

  // Result status
  typedef enum logic [STAT_W-1:0] {
    ST_OK              = 3'd0,
    ST_NO_SPACE        = 3'd1,
    ST_NOT_FOUND       = 3'd2,
    ST_INVALID_SIZE    = 3'd3,
    ST_NOT_SUPPORTED   = 3'd4,
    ST_NOT_IMPLEMENTED = 3'd5
  } arpc_status_t;

endpackage

[hw/rtl/arpc_if.sv]
// Valid/ready channel interfaces for operation input and result output.
// Depends on arpc_pkg for field widths.
interface arpc_in_if;
  logic                          valid;
  logic                          ready;
  logic [arpc_pkg::FUNC_W-1:0]   func;
  logic [arpc_pkg::MAC_W-1:0]    mac_addr;
  logic [arpc_pkg::IP_W-1:0]     ip_addr;
  logic [15:0]                   hw_type;
  logic [15:0]                   ptype;
  logic [15:0]                   opcode;
  logic [7:0]                    hw_len;
  logic [7:0]                    pa_len;
  logic [arpc_pkg::PLEN_W-1:0]   payload_len;
  logic [arpc_pkg::IP_W-1:0]     target_ip;
  logic [arpc_pkg::MAC_W-1:0]    frame_src_mac;

  modport source (output valid, func, mac_addr, ip_addr, hw_type, ptype, opcode,
                  hw_len, pa_len, payload_len, target_ip, frame_src_mac,
                  input ready);
  modport sink (input valid, func, mac_addr, ip_addr, hw_type, ptype, opcode,
                hw_len, pa_len, payload_len, target_ip, frame_src_mac,
                output ready);
endinterface

interface arpc_out_if;
  logic                          valid;
  logic                          ready;
  logic [arpc_pkg::STAT_W-1:0]   status;
  logic [arpc_pkg::MAC_W-1:0]    found_mac;
  logic [arpc_pkg::IP_W-1:0]     found_ip;
  logic                          reply_needed;
  logic [arpc_pkg::MAC_W-1:0]    reply_dest_mac;
  logic                          query_needed;

  modport source (output valid, status, found_mac, found_ip, reply_needed,
                  reply_dest_mac, query_needed, input ready);
  modport sink (input valid, status, found_mac, found_ip, reply_needed,
                reply_dest_mac, query_needed, output ready);
endinterface

[hw/rtl/arpc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module arpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/arp_cache_and_receive_core.sv]
// ARP cache and receive core: slot table, sequential scan unit, APB registers.
// Depends on arpc_pkg, arpc_in_if/arpc_out_if and arpc_ram.
//
//   channel   handshake          payload
//   in_if     valid/ready        func, addresses, ARP header fields
//   out_if    valid/ready        status, found entry, reply and query flags
//   cfg_*     APB psel/penable   local_ip at 0x0, local_mac at 0x8
//
// Table operations (add, find, delete, resolve, receive of a reply that passes
// the header checks) walk the slot RAM through one compare unit, one entry per
// cycle, then drain and finish. Other receive cases and unknown codes skip the
// walk and go from accept straight to finish; a new transaction is accepted
// only in idle. rst_n clears the valid bits at once, so no clearing pass is
// needed. A stalled result holds in the output register while the next
// transaction is accepted; that one waits in finish until the slot frees.
module arp_cache_and_receive_core (
  input  logic                          clk,
  input  logic                          rst_n,
  arpc_in_if.sink                       in_if,
  arpc_out_if.source                    out_if,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [arpc_pkg::PADDR_W-1:0]  cfg_paddr,
  input  logic [arpc_pkg::PDATA_W-1:0]  cfg_pwdata,
  output logic [arpc_pkg::PDATA_W-1:0]  cfg_prdata,
  output logic                          cfg_pready
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_FINISH} state_t;

  state_t state_r, state_nxt;

  // Configuration registers
  logic [arpc_pkg::IP_W-1:0]  local_ip_r;
  logic [arpc_pkg::MAC_W-1:0] local_mac_r;

  // Latched operation
  logic [arpc_pkg::FUNC_W-1:0] func_r;
  logic [arpc_pkg::MAC_W-1:0]  mac_r;
  logic [arpc_pkg::IP_W-1:0]   ip_r;
  logic [arpc_pkg::IP_W-1:0]   tip_r;
  logic [arpc_pkg::MAC_W-1:0]  fsrc_r;
  logic [15:0]                 op_r;
  logic                        type_ok_r;
  logic                        size_ok_r;
  logic                        use_mac_r;

  // Scan unit
  logic [arpc_pkg::TABLE_ENTRIES-1:0] valid_r;
  logic [arpc_pkg::IDX_W-1:0]         scan_idx_r;
  logic [arpc_pkg::IDX_W-1:0]         cmp_idx_r;
  logic                               cmp_vld_r;
  logic                               hit_found_r;
  logic [arpc_pkg::IDX_W-1:0]         hit_idx_r;
  logic [arpc_pkg::IP_W-1:0]          hit_ip_r;
  logic [arpc_pkg::MAC_W-1:0]         hit_mac_r;
  logic                               free_found_r;
  logic [arpc_pkg::IDX_W-1:0]         free_idx_r;
  logic [arpc_pkg::WORD_W-1:0]        rd_word;

  // Output register
  logic                          out_valid_r;
  arpc_pkg::arpc_status_t        status_r;
  logic [arpc_pkg::MAC_W-1:0]    found_mac_r;
  logic [arpc_pkg::IP_W-1:0]     found_ip_r;
  logic                          reply_r;
  logic [arpc_pkg::MAC_W-1:0]    reply_dest_r;
  logic                          query_r;

  // Combinational decode
  logic                          in_acc;
  logic                          cfg_wr;
  logic [9:0]                    need_len;
  logic                          in_type_ok;
  logic                          in_size_ok;
  logic                          in_scan;
  logic                          cmp_match;
  logic                          slot_hit;
  logic                          slot_free;
  logic                          fin_go;
  arpc_pkg::arpc_status_t        fin_status;
  logic [arpc_pkg::MAC_W-1:0]    fin_fmac;
  logic [arpc_pkg::IP_W-1:0]     fin_fip;
  logic                          fin_rep;
  logic                          fin_qry;
  logic                          tbl_we;
  logic [arpc_pkg::IDX_W-1:0]    tbl_widx;
  logic                          tbl_clr;

  assign in_acc    = in_if.valid && in_if.ready;
  assign in_if.ready = (state_r == S_IDLE);
  assign cfg_wr    = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[3] == arpc_pkg::REG_LOCAL_MAC) ?
                      {16'b0, local_mac_r} : {32'b0, local_ip_r};

  // Receive header checks on the incoming transaction
  assign need_len   = {1'b0, in_if.hw_len, 1'b0} + {1'b0, in_if.pa_len, 1'b0};
  assign in_type_ok = (in_if.hw_type == arpc_pkg::HW_ETHERNET) &&
                      (in_if.ptype == arpc_pkg::PROTO_IPV4);
  assign in_size_ok = (in_if.payload_len >= {1'b0, need_len});

  // Decide whether the transaction walks the table
  always_comb begin
    case (in_if.func)
      arpc_pkg::FN_ADD, arpc_pkg::FN_FIND_IP, arpc_pkg::FN_FIND_MAC,
      arpc_pkg::FN_DEL_MAC, arpc_pkg::FN_DEL_IP, arpc_pkg::FN_RESOLVE:
        in_scan = 1'b1;
      arpc_pkg::FN_RECEIVE:
        in_scan = in_type_ok && in_size_ok && (in_if.opcode == arpc_pkg::OP_REPLY);
      default:
        in_scan = 1'b0;
    endcase
  end

  // Slot storage: {mac, ip} per entry
  arpc_ram #(
    .WIDTH (arpc_pkg::WORD_W),
    .DEPTH (arpc_pkg::TABLE_ENTRIES)
  ) u_slot_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_widx),
    .wdata ({mac_r, ip_r}),
    .re    (state_r == S_SCAN),
    .raddr (scan_idx_r),
    .rdata (rd_word)
  );

  // Shared compare unit on the entry read last cycle
  assign cmp_match = use_mac_r ? (rd_word[arpc_pkg::WORD_W-1:arpc_pkg::IP_W] == mac_r)
                               : (rd_word[arpc_pkg::IP_W-1:0] == ip_r);
  assign slot_hit  = cmp_vld_r && valid_r[cmp_idx_r] && cmp_match;
  assign slot_free = cmp_vld_r && !valid_r[cmp_idx_r];

  // Result and table update in the finish state, once any scan is done
  assign fin_go = (state_r == S_FINISH) && (!out_valid_r || out_if.ready);

  always_comb begin
    fin_status = arpc_pkg::ST_OK;
    fin_fmac   = '0;
    fin_fip    = '0;
    fin_rep    = 1'b0;
    fin_qry    = 1'b0;
    tbl_we     = 1'b0;
    tbl_widx   = free_idx_r;
    tbl_clr    = 1'b0;
    case (func_r)
      arpc_pkg::FN_ADD: begin
        if (free_found_r) begin
          tbl_we = fin_go;
        end else begin
          fin_status = arpc_pkg::ST_NO_SPACE;
        end
      end
      arpc_pkg::FN_FIND_IP, arpc_pkg::FN_FIND_MAC: begin
        if (hit_found_r) begin
          fin_fmac = hit_mac_r;
          fin_fip  = hit_ip_r;
        end else begin
          fin_status = arpc_pkg::ST_NOT_FOUND;
        end
      end
      arpc_pkg::FN_DEL_MAC, arpc_pkg::FN_DEL_IP: begin
        if (hit_found_r) begin
          tbl_clr = fin_go;
        end else begin
          fin_status = arpc_pkg::ST_NOT_FOUND;
        end
      end
      arpc_pkg::FN_RECEIVE: begin
        if (!type_ok_r) begin
          fin_status = arpc_pkg::ST_NOT_SUPPORTED;
        end else if (op_r == arpc_pkg::OP_REQUEST) begin
          if (!size_ok_r) begin
            fin_status = arpc_pkg::ST_INVALID_SIZE;
          end else if (tip_r != local_ip_r) begin
            fin_status = arpc_pkg::ST_NOT_FOUND;
          end else begin
            fin_rep = 1'b1;
          end
        end else if (op_r == arpc_pkg::OP_REPLY) begin
          // Refresh the first match, else take a free slot, else drop
          if (size_ok_r) begin
            if (hit_found_r) begin
              tbl_we   = fin_go;
              tbl_widx = hit_idx_r;
            end else begin
              tbl_we = fin_go && free_found_r;
            end
          end
        end else begin
          fin_status = arpc_pkg::ST_NOT_IMPLEMENTED;
        end
      end
      arpc_pkg::FN_RESOLVE: begin
        fin_qry = !hit_found_r;
      end
      default: begin
        fin_status = arpc_pkg::ST_NOT_IMPLEMENTED;
      end
    endcase
  end

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_acc) state_nxt = in_scan ? S_SCAN : S_FINISH;
      S_SCAN:   if (scan_idx_r == arpc_pkg::LAST_IDX) state_nxt = S_DRAIN;
      S_DRAIN:  state_nxt = S_FINISH;
      S_FINISH: if (fin_go) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // State, scan control and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      local_ip_r   <= '0;
      local_mac_r  <= '0;
      valid_r      <= '0;
      scan_idx_r   <= '0;
      cmp_vld_r    <= 1'b0;
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // Register writes
      if (cfg_wr) begin
        if (cfg_paddr[3] == arpc_pkg::REG_LOCAL_MAC) begin
          local_mac_r <= cfg_pwdata[arpc_pkg::MAC_W-1:0];
        end else begin
          local_ip_r <= cfg_pwdata[arpc_pkg::IP_W-1:0];
        end
      end

      // Start a fresh scan on accept
      if (in_acc) begin
        scan_idx_r   <= '0;
        hit_found_r  <= 1'b0;
        free_found_r <= 1'b0;
      end

      // Advance the read address and pipe it to the compare stage
      cmp_vld_r <= (state_r == S_SCAN);
      if (state_r == S_SCAN) begin
        cmp_idx_r <= scan_idx_r;
        if (scan_idx_r != arpc_pkg::LAST_IDX) begin
          scan_idx_r <= scan_idx_r + 1'b1;
        end
      end

      // Keep the first match and the first free slot
      if (slot_hit && !hit_found_r) begin
        hit_found_r <= 1'b1;
        hit_idx_r   <= cmp_idx_r;
        hit_ip_r    <= rd_word[arpc_pkg::IP_W-1:0];
        hit_mac_r   <= rd_word[arpc_pkg::WORD_W-1:arpc_pkg::IP_W];
      end
      if (slot_free && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= cmp_idx_r;
      end

      // Valid marks
      if (tbl_we) begin
        valid_r[tbl_widx] <= 1'b1;
      end
      if (tbl_clr) begin
        valid_r[hit_idx_r] <= 1'b0;
      end

      // Output register: load a new result, else drop the one taken
      if (fin_go) begin
        out_valid_r  <= 1'b1;
        status_r     <= fin_status;
        found_mac_r  <= fin_fmac;
        found_ip_r   <= fin_fip;
        reply_r      <= fin_rep;
        reply_dest_r <= fin_rep ? fsrc_r : '0;
        query_r      <= fin_qry;
      end else if (out_valid_r && out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Operand capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r    <= in_if.func;
      mac_r     <= in_if.mac_addr;
      ip_r      <= in_if.ip_addr;
      tip_r     <= in_if.target_ip;
      fsrc_r    <= in_if.frame_src_mac;
      op_r      <= in_if.opcode;
      type_ok_r <= in_type_ok;
      size_ok_r <= in_size_ok;
      use_mac_r <= (in_if.func == arpc_pkg::FN_FIND_MAC) ||
                   (in_if.func == arpc_pkg::FN_DEL_MAC);
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.status         = status_r;
  assign out_if.found_mac      = found_mac_r;
  assign out_if.found_ip       = found_ip_r;
  assign out_if.reply_needed   = reply_r;
  assign out_if.reply_dest_mac = reply_dest_r;
  assign out_if.query_needed   = query_r;

endmodule

[hw/rtl/arpc_checker.sv]
// Port-level checks for the ARP cache core, bound to the top level.
// Depends on arpc_pkg and arp_cache_and_receive_core_macros.svh.
`include "arp_cache_and_receive_core_macros.svh"

module arpc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [arpc_pkg::STAT_W-1:0]  out_status,
  input logic                         out_reply_needed,
  input logic                         out_query_needed
);

  // Hold a result until it is taken
  `ARPC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // One transaction at a time in the scan unit
  `ARPC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")

  // Flags only come with an ok status
  `ARPC_ASSERT_NOW(a_flag_ok, out_valid && (out_reply_needed || out_query_needed), out_status == arpc_pkg::ST_OK, "flag with error status")

  // Reply and query never both
  `ARPC_ASSERT_NOW(a_flag_excl, out_valid && out_reply_needed, !out_query_needed, "reply and query together")

endmodule

bind arp_cache_and_receive_core arpc_checker u_arpc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_if.valid),
  .in_ready         (in_if.ready),
  .out_valid        (out_if.valid),
  .out_ready        (out_if.ready),
  .out_status       (out_if.status),
  .out_reply_needed (out_if.reply_needed),
  .out_query_needed (out_if.query_needed)
);
